[src/rwl_pkg.sv]
// Shared constants, mode codes and controller/datapath interface types.
`timescale 1ns / 1ps
package rwl_pkg;

  localparam int NUM_BLOCKS  = 1024;
  localparam int READER_BITS = 16;
  localparam int ADDR_W      = $clog2(NUM_BLOCKS);
  localparam int BLOCK_ID_W  = 10;
  localparam int WORD_W      = READER_BITS + 1;  // reader count above the writer flag
  localparam int ENTRY_W     = WORD_W + 1;       // present bit on top of the lock word

  localparam logic [READER_BITS-1:0] READER_MAX = {READER_BITS{1'b1}};

  localparam logic [1:0] MODE_RELEASE = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_WRITE   = 2'd2;

  typedef struct packed {
    logic capture;  // latch the request beat
    logic clr_wr;   // write one zero entry of the clearing pass
    logic upd;      // entry read data is valid: update table and result
  } rwl_cmd_t;

  typedef struct packed {
    logic clr_last; // clearing pass is at the last entry
    logic out_free; // result register is free on the next cycle
  } rwl_stat_t;

endpackage

[src/rwl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/rwl_ctrl.sv]
// Sequencer: clearing pass, request capture, entry read, update.
`timescale 1ns / 1ps
module rwl_ctrl import rwl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rwl_stat_t stat,
  output rwl_cmd_t  cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RD    = 2'd2;
  localparam logic [1:0] ST_UPD   = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.clr_wr  = (state_r == ST_CLEAR);
  assign cmd.upd     = (state_r == ST_UPD);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RD;
      end
      // hold here, re-reading the entry, until the result register frees up
      ST_RD: begin
        if (stat.out_free) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/rwl_dp.sv]
// Datapath: request latch, lock table RAM, entry update and result register.
`timescale 1ns / 1ps
module rwl_dp import rwl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_mode,
  input  logic [BLOCK_ID_W-1:0] in_block_id,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_granted,
  input  rwl_cmd_t              cmd,
  output rwl_stat_t             stat
);

  logic [1:0]            mode_r;
  logic [BLOCK_ID_W-1:0] blk_r;
  logic [ADDR_W-1:0]     clr_cnt_r;
  logic                  out_valid_r;
  logic                  granted_r;

  logic [ENTRY_W-1:0]     rdata;
  logic [ENTRY_W-1:0]     wdata;
  logic [ADDR_W-1:0]      waddr;
  logic [ADDR_W-1:0]      blk_addr;
  logic                   we;
  logic                   in_range;
  logic                   present;
  logic [WORD_W-1:0]      word;
  logic [READER_BITS-1:0] readers;
  logic                   ok;
  logic                   upd_we;
  logic [WORD_W-1:0]      new_word;
  logic                   has_result;

  assign in_range = (32'(blk_r) < 32'(NUM_BLOCKS));
  assign blk_addr = ADDR_W'(blk_r);
  assign present  = rdata[ENTRY_W-1];
  assign word     = rdata[WORD_W-1:0];
  assign readers  = word[WORD_W-1:1];

  always_comb begin
    ok       = 1'b0;
    upd_we   = 1'b0;
    new_word = word;
    case (mode_r)
      MODE_WRITE: begin
        ok       = !present || (word == '0);
        upd_we   = ok;
        new_word = WORD_W'(1);
      end
      MODE_READ: begin
        ok       = present && !word[0] && (readers != READER_MAX);
        upd_we   = ok;
        new_word = {readers + READER_BITS'(1), 1'b0};
      end
      MODE_RELEASE: begin
        // a present but free block rewrites its own zero word; an absent one is not written
        upd_we = present;
        if (word[0]) begin
          new_word = '0;
        end else if (readers != '0) begin
          new_word = {readers - READER_BITS'(1), 1'b0};
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign has_result = (mode_r != MODE_RELEASE);

  assign we    = cmd.clr_wr || (cmd.upd && in_range && upd_we);
  assign waddr = cmd.clr_wr ? clr_cnt_r : blk_addr;
  assign wdata = cmd.clr_wr ? '0 : {1'b1, new_word};

  rwl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (blk_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      blk_r  <= in_block_id;
    end
    if (cmd.upd && has_result) begin
      granted_r <= in_range && ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (cmd.upd && has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.clr_last = (clr_cnt_r == ADDR_W'(NUM_BLOCKS - 1));
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_granted = granted_r;

endmodule

[src/reader_writer_lock_table_unit.sv]
// Reader/writer lock table: one RAM entry per block, updated read-modify-write.
// Flow: a request beat is accepted, its entry is read from the table RAM, then
// the entry is written back and the result register loaded (a release request
// loads no result). A new request is taken only once the read-modify-write of
// the last one is through, and a stalled result holds it in the entry read.
// Reset: synchronous rst_n; afterwards the table is zeroed one entry per cycle,
// all NUM_BLOCKS (1024) entries, and in_ready stays low during that pass.
`timescale 1ns / 1ps
module reader_writer_lock_table_unit import rwl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_mode,
  input  logic [BLOCK_ID_W-1:0] in_block_id,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_granted
);

  rwl_cmd_t  cmd;
  rwl_stat_t stat;

  rwl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rwl_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mode     (in_mode),
    .in_block_id (in_block_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_granted (out_granted),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

[src/rwl_checker.sv]
// Port-level checks for the lock table unit, bound to the top level.
`timescale 1ns / 1ps
module rwl_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_granted
);

  // clearing pass follows every reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  // one request in flight: busy for the read and update cycles
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("new request taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_granted)))
    else $error("result beat dropped or changed while stalled");

endmodule

bind reader_writer_lock_table_unit rwl_checker u_rwl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_granted (out_granted)
);
